// ===== rtl/vrt_pkg.sv =====
// Package for the voxel ray walker: status codes, axis codes and the
// request classification carried between front and back. No dependencies.
`timescale 1ns / 1ps
package vrt_pkg;
  localparam logic [1:0] ST_QUERY = 2'd0;
  localparam logic [1:0] ST_HIT   = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;

  localparam logic [1:0] AX_X    = 2'd0;
  localparam logic [1:0] AX_Y    = 2'd1;
  localparam logic [1:0] AX_Z    = 2'd2;
  localparam logic [1:0] AX_NONE = 2'd3;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  typedef enum logic [2:0] {
    BK_IDLE, BK_DIV, BK_MUL, BK_CHECK, BK_OUT
  } bk_state_t;

  // One queued request as seen by the back part.
  typedef struct packed {
    logic        kind;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] oz;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] dz;
    logic        solid;
  } req_t;
endpackage

// ===== rtl/vrt_if.sv =====
// Channel interfaces for the voxel ray walker: ray/answer requests in,
// results out. Depends on nothing.
`timescale 1ns / 1ps
interface vrt_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;
  logic [15:0] dir_x;
  logic [15:0] dir_y;
  logic [15:0] dir_z;
  logic        voxel_solid;
  modport source (output valid, kind, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  voxel_solid, input ready);
  modport sink (input valid, kind, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                voxel_solid, output ready);
endinterface

interface vrt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] voxel_x;
  logic [15:0] voxel_y;
  logic [15:0] voxel_z;
  logic [1:0]  normal_x;
  logic [1:0]  normal_y;
  logic [1:0]  normal_z;
  modport source (output valid, status, voxel_x, voxel_y, voxel_z, normal_x, normal_y,
                  normal_z, input ready);
  modport sink (input valid, status, voxel_x, voxel_y, voxel_z, normal_x, normal_y,
                normal_z, output ready);
endinterface

// ===== rtl/vrt_front.sv =====
// Front part: accepts requests into a two-entry queue, in order.
// Depends on vrt_pkg and vrt_in_if.
`timescale 1ns / 1ps
module vrt_front (
  input  logic          clk,
  input  logic          rst,
  vrt_in_if.sink        in_ch,
  output logic          q_valid,
  input  logic          q_pop,
  output vrt_pkg::req_t q_head
);
  vrt_pkg::req_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  vrt_pkg::req_t incoming;

  assign incoming = '{kind: in_ch.kind, ox: in_ch.origin_x, oy: in_ch.origin_y,
                      oz: in_ch.origin_z, dx: in_ch.dir_x, dy: in_ch.dir_y,
                      dz: in_ch.dir_z, solid: in_ch.voxel_solid};
  assign in_ch.ready = (count != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= incoming;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== rtl/vrt_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Used by the back part for the per-ray t_delta reciprocals; no dependencies.
`timescale 1ns / 1ps
module vrt_div #(
  parameter int NW = 38,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [DW:0]   rem;
  logic [NW-1:0] nsh;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], nsh[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      rem  <= '0;
      nsh  <= num;
      quo  <= '0;
    end else if (busy) begin
      nsh <= {nsh[NW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule

// ===== rtl/vrt_back.sv =====
// Back part: ray setup (reciprocal divide, one axis at a time), stepping,
// end test and the result register. Depends on vrt_pkg, vrt_div, vrt_out_if.
`timescale 1ns / 1ps
module vrt_back #(
  parameter int T_FRAC_BITS    = 24,
  parameter int COORD_INT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    max_distance,
  input  logic          q_valid,
  output logic          q_pop,
  input  vrt_pkg::req_t q_head,
  vrt_out_if.source     out_ch
);
  localparam int PFB = 32 - COORD_INT_BITS;
  localparam int NW  = T_FRAC_BITS + 15;
  localparam logic [31:0] T_ONE = 32'(64'd1 << T_FRAC_BITS);

  vrt_pkg::bk_state_t state, state_next;
  logic [15:0] vox [3];
  logic [31:0] tmax [3];
  logic [31:0] tdel [3];
  logic [1:0]  stp [3];
  logic [1:0]  last_axis;
  logic        ray_active;
  logic [1:0]  ax;
  logic [31:0] org [3];
  logic [15:0] dir [3];
  logic [23:0] mag;
  logic [23:0] mag_r;
  logic        div_go;
  logic        div_wait;
  logic        div_busy;
  logic [NW-1:0] div_q;
  logic [31:0] delta_sat;
  logic [PFB:0] mfac;
  logic [63:0] prod;
  logic [1:0]  dsel;
  logic [31:0] step_sum;
  logic        all_past;

  assign org[0] = q_head.ox;
  assign org[1] = q_head.oy;
  assign org[2] = q_head.oz;
  assign dir[0] = q_head.dx;
  assign dir[1] = q_head.dy;
  assign dir[2] = q_head.dz;

  // Magnitude of the extent dir * max_distance for the axis in setup.
  always_comb begin
    logic signed [24:0] d;
    d = $signed(dir[ax]) * $signed({1'b0, max_distance});
    mag = d[24] ? 24'(-d) : d[23:0];
  end

  vrt_div #(.NW(NW), .DW(24)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(NW'(1) << (NW - 1)), .den(mag),
    .busy(div_busy), .quo(div_q)
  );

  assign delta_sat = (64'(div_q) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(div_q);
  assign mfac = (stp[ax] == 2'b01) ? ((PFB+1)'(1) << PFB) - {1'b0, org[ax][PFB-1:0]}
                                   : {1'b0, org[ax][PFB-1:0]};
  assign prod = 64'(tdel[ax]) * 64'(mfac);

  always_comb begin
    if (tmax[0] < tmax[1]) dsel = (tmax[0] < tmax[2]) ? vrt_pkg::AX_X : vrt_pkg::AX_Z;
    else                   dsel = (tmax[1] < tmax[2]) ? vrt_pkg::AX_Y : vrt_pkg::AX_Z;
  end
  always_comb begin
    logic [32:0] s;
    s = {1'b0, tmax[dsel]} + {1'b0, tdel[dsel]};
    step_sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
  end
  assign all_past = (tmax[0] > T_ONE) && (tmax[1] > T_ONE) && (tmax[2] > T_ONE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      vrt_pkg::BK_IDLE: begin
        if (q_valid && !out_ch.valid) begin
          if (q_head.kind == vrt_pkg::KIND_START) state_next = vrt_pkg::BK_DIV;
          else if (ray_active) state_next = q_head.solid ? vrt_pkg::BK_OUT
                                                         : vrt_pkg::BK_CHECK;
        end
      end
      vrt_pkg::BK_DIV:   if (div_wait && !div_busy) state_next = vrt_pkg::BK_MUL;
      vrt_pkg::BK_MUL:   state_next = (ax == vrt_pkg::AX_Z) ? vrt_pkg::BK_CHECK
                                                            : vrt_pkg::BK_DIV;
      vrt_pkg::BK_CHECK: state_next = vrt_pkg::BK_OUT;
      vrt_pkg::BK_OUT:   state_next = vrt_pkg::BK_IDLE;
      default:           state_next = vrt_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop  = 1'b0;
    div_go = 1'b0;
    unique case (state)
      vrt_pkg::BK_IDLE:  q_pop = q_valid && !out_ch.valid && q_head.kind == vrt_pkg::KIND_ANSWER
                                 && !ray_active;
      vrt_pkg::BK_DIV:   div_go = !div_wait && mag != '0;
      vrt_pkg::BK_OUT:   q_pop = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= vrt_pkg::BK_IDLE;
      ray_active <= 1'b0;
      last_axis  <= vrt_pkg::AX_NONE;
      out_ch.valid <= 1'b0;
      div_wait   <= 1'b0;
      ax         <= vrt_pkg::AX_X;
      for (int i = 0; i < 3; i++) begin
        vox[i] <= '0; tmax[i] <= '0; tdel[i] <= '0; stp[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        vrt_pkg::BK_IDLE: begin
          ax <= vrt_pkg::AX_X;
          div_wait <= 1'b0;
          if (state_next == vrt_pkg::BK_CHECK) begin
            vox[dsel]  <= vox[dsel] + {{14{stp[dsel][1]}}, stp[dsel]};
            tmax[dsel] <= step_sum;
            last_axis  <= dsel;
          end
        end
        vrt_pkg::BK_DIV: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
            mag_r    <= mag;
            stp[ax]  <= (mag == '0) ? 2'b00 : (dir[ax][15] ? 2'b11 : 2'b01);
            vox[ax]  <= 16'($signed(org[ax]) >>> PFB);
          end else if (!div_busy) begin
            tdel[ax] <= (mag_r == '0) ? 32'hFFFF_FFFF : delta_sat;
          end
        end
        vrt_pkg::BK_MUL: begin
          div_wait <= 1'b0;
          if (stp[ax] == 2'b00) tmax[ax] <= 32'hFFFF_FFFF;
          else tmax[ax] <= ((prod >> PFB) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                            : 32'(prod >> PFB);
          ax <= ax + 2'd1;
          if (ax == vrt_pkg::AX_Z) begin
            last_axis  <= vrt_pkg::AX_NONE;
            ray_active <= 1'b1;
          end
        end
        vrt_pkg::BK_CHECK: begin
          out_ch.status <= all_past ? vrt_pkg::ST_MISS : vrt_pkg::ST_QUERY;
          if (all_past) ray_active <= 1'b0;
          out_ch.normal_x <= '0; out_ch.normal_y <= '0; out_ch.normal_z <= '0;
          out_ch.voxel_x <= vox[0]; out_ch.voxel_y <= vox[1]; out_ch.voxel_z <= vox[2];
        end
        vrt_pkg::BK_OUT: begin
          out_ch.valid <= 1'b1;
          if (q_head.kind == vrt_pkg::KIND_ANSWER && q_head.solid) begin
            // A solid answer: the normal points back along the last crossed axis.
            ray_active <= 1'b0;
            out_ch.status <= vrt_pkg::ST_HIT;
            out_ch.voxel_x <= vox[0]; out_ch.voxel_y <= vox[1]; out_ch.voxel_z <= vox[2];
            out_ch.normal_x <= (last_axis == vrt_pkg::AX_X) ? 2'(-stp[0]) : 2'b00;
            out_ch.normal_y <= (last_axis == vrt_pkg::AX_Y) ? 2'(-stp[1]) : 2'b00;
            out_ch.normal_z <= (last_axis == vrt_pkg::AX_Z || last_axis == vrt_pkg::AX_NONE)
                               ? 2'(-stp[2]) : 2'b00;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/voxel_ray_traversal_top.sv =====
// Top level of the voxel ray walker: front queue, back sequencer, config reg.
// Depends on vrt_pkg, vrt_if, vrt_front, vrt_div, vrt_back.
//
//  channel   dir  handshake    payload
//  in_ch     in   valid/ready  kind, origin_x/y/z, dir_x/y/z, voxel_solid
//  out_ch    out  valid/ready  status, voxel_x/y/z, normal_x/y/z
//  cfg       in   cfg_we       cfg_data = max_distance
//
// An accepted request is registered in the queue before the back part sees it. An
// answer request passes there through the step, the check and the result register;
// a solid one skips the step and the check. The back part takes its next request in
// the cycle after the result is taken. A start request runs each axis through the
// reciprocal divide and the multiply in turn, on the one-bit-per-cycle reciprocal
// divider shared by the axes; an axis with zero extent skips the divide.
// Reset is synchronous; max_distance returns to 8. The two-entry queue keeps
// accepting while a result waits in the output register, until it is full.
`timescale 1ns / 1ps
module voxel_ray_traversal_top #(
  parameter int T_FRAC_BITS    = 24,
  parameter int COORD_INT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  vrt_in_if.sink     in_ch,
  vrt_out_if.source  out_ch
);
  logic [7:0]    max_distance;
  logic          q_valid;
  logic          q_pop;
  vrt_pkg::req_t q_head;

  always_ff @(posedge clk) begin
    if (rst) max_distance <= 8'd8;
    else if (cfg_we) max_distance <= cfg_data;
  end

  vrt_front u_front (.clk(clk), .rst(rst), .in_ch(in_ch), .q_valid(q_valid),
                     .q_pop(q_pop), .q_head(q_head));

  vrt_back #(.T_FRAC_BITS(T_FRAC_BITS), .COORD_INT_BITS(COORD_INT_BITS)) u_back (
    .clk(clk), .rst(rst), .max_distance(max_distance), .q_valid(q_valid),
    .q_pop(q_pop), .q_head(q_head), .out_ch(out_ch)
  );
endmodule

// ===== rtl/vrt_checker.sv =====
// Port-level checks for the voxel ray walker, bound to the top level.
// Depends on vrt_pkg.
`timescale 1ns / 1ps
module vrt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [1:0] normal_x,
  input logic [1:0] normal_y,
  input logic [1:0] normal_z
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status");
  a_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != vrt_pkg::ST_HIT |-> normal_x == 2'd0 && normal_y == 2'd0
    && normal_z == 2'd0) else $error("normal on non-hit");
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == vrt_pkg::ST_HIT |-> $countones({normal_x != 2'd0,
    normal_y != 2'd0, normal_z != 2'd0}) <= 1) else $error("two normals");
endmodule

bind voxel_ray_traversal_top vrt_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .normal_x(out_ch.normal_x), .normal_y(out_ch.normal_y),
  .normal_z(out_ch.normal_z)
);

// ===== sim/voxel_ray_traversal_top_tb.sv =====
// Self-checking testbench for voxel_ray_traversal_top: drives ray and answer
// requests, predicts every result and compares it. Depends on vrt_pkg, vrt_if.
`timescale 1ns / 1ps
module voxel_ray_traversal_top_tb;
  localparam longint unsigned T_SAT = 64'hFFFF_FFFF;
  localparam longint unsigned T_ONE = 64'd1 << 24;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] vx, vy, vz;
    logic [1:0]  nx, ny, nz;
  } walk_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'd0;

  vrt_in_if  in_ch ();
  vrt_out_if out_ch ();

  voxel_ray_traversal_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state of the walker.
  logic [7:0]  max_dist;
  logic [15:0] vox[3];
  logic [31:0] tmax[3];
  logic [31:0] tdel[3];
  logic [1:0]  stp[3];
  logic [1:0]  last_ax;
  bit          ray_on;

  walk_res_t expected_results[$];
  int errors = 0;
  int n_rays = 0, n_hits = 0, n_misses = 0, n_queries = 0, n_items = 0;
  bit calm = 1'b0;

  function automatic void setup_axis(int ax, logic [31:0] org, logic [15:0] dir);
    longint d;
    longint unsigned mag, delta, tm, frac;
    d = longint'($signed(dir)) * longint'(max_dist);
    mag = (d < 0) ? -d : d;
    frac = 64'(org[15:0]);
    vox[ax] = org[31:16];
    if (d == 0) begin
      delta = T_SAT;
      tm = T_SAT;
      stp[ax] = 2'b00;
    end else begin
      delta = (64'd1 << 38) / mag;
      if (delta > T_SAT) delta = T_SAT;
      if (d > 0) tm = (delta * (64'd65536 - frac)) >> 16;
      else tm = (delta * frac) >> 16;
      if (tm > T_SAT) tm = T_SAT;
      stp[ax] = (d > 0) ? 2'b01 : 2'b11;
    end
    tdel[ax] = delta[31:0];
    tmax[ax] = tm[31:0];
  endfunction

  function automatic void push_result(logic [1:0] st, logic [1:0] nx, logic [1:0] ny,
                                      logic [1:0] nz);
    walk_res_t r;
    r.status = st;
    r.vx = vox[0]; r.vy = vox[1]; r.vz = vox[2];
    r.nx = nx; r.ny = ny; r.nz = nz;
    expected_results.push_back(r);
  endfunction

  function automatic void query_or_miss();
    if (tmax[0] > T_ONE && tmax[1] > T_ONE && tmax[2] > T_ONE) begin
      ray_on = 1'b0;
      push_result(vrt_pkg::ST_MISS, 2'b00, 2'b00, 2'b00);
    end else begin
      push_result(vrt_pkg::ST_QUERY, 2'b00, 2'b00, 2'b00);
    end
  endfunction

  function automatic void predict_walk(logic kind, logic [31:0] ox, oy, oz,
                                       logic [15:0] dx, dy, dz, logic solid);
    int ax;
    longint unsigned sum;
    if (kind == vrt_pkg::KIND_START) begin
      setup_axis(0, ox, dx);
      setup_axis(1, oy, dy);
      setup_axis(2, oz, dz);
      last_ax = vrt_pkg::AX_NONE;
      ray_on = 1'b1;
      query_or_miss();
      return;
    end
    if (!ray_on) return;
    if (solid) begin
      ray_on = 1'b0;
      if (last_ax == vrt_pkg::AX_X) push_result(vrt_pkg::ST_HIT, 2'(-stp[0]), 2'b00, 2'b00);
      else if (last_ax == vrt_pkg::AX_Y)
        push_result(vrt_pkg::ST_HIT, 2'b00, 2'(-stp[1]), 2'b00);
      else push_result(vrt_pkg::ST_HIT, 2'b00, 2'b00, 2'(-stp[2]));
      return;
    end
    if (tmax[0] < tmax[1]) ax = (tmax[0] < tmax[2]) ? 0 : 2;
    else ax = (tmax[1] < tmax[2]) ? 1 : 2;
    vox[ax] = vox[ax] + {{14{stp[ax][1]}}, stp[ax]};
    sum = longint'(tmax[ax]) + longint'(tdel[ax]);
    tmax[ax] = (sum > T_SAT) ? 32'hFFFF_FFFF : sum[31:0];
    last_ax = 2'(ax);
    query_or_miss();
  endfunction

  // Sends one request; valid stays high after acceptance until the next gap.
  task automatic send_req(logic kind, logic [31:0] ox, oy, oz,
                          logic [15:0] dx, dy, dz, logic solid);
    while (!calm && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.origin_x <= ox; in_ch.origin_y <= oy; in_ch.origin_z <= oz;
    in_ch.dir_x <= dx; in_ch.dir_y <= dy; in_ch.dir_z <= dz;
    in_ch.voxel_solid <= solid;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (kind == vrt_pkg::KIND_START) n_rays++;
    n_items++;
    predict_walk(kind, ox, oy, oz, dx, dy, dz, solid);
  endtask

  task automatic answer(logic solid);
    send_req(vrt_pkg::KIND_ANSWER, $urandom, $urandom, $urandom, 16'($urandom),
             16'($urandom), 16'($urandom), solid);
  endtask

  // One ray: answers are empty voxels until hit_at answers have gone by.
  task automatic walk_ray(logic [31:0] ox, oy, oz, logic [15:0] dx, dy, dz, int hit_at);
    int k;
    k = 0;
    send_req(vrt_pkg::KIND_START, ox, oy, oz, dx, dy, dz, 1'($urandom_range(1)));
    while (ray_on) begin
      answer(k == hit_at);
      k++;
    end
  endtask

  task automatic set_max_dist(logic [7:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_dist = v;
  endtask

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    walk_res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d", out_ch.status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.status == vrt_pkg::ST_HIT) n_hits++;
        else if (e.status == vrt_pkg::ST_MISS) n_misses++;
        else n_queries++;
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status); errors++;
        end
        if (out_ch.voxel_x !== e.vx) begin
          $error("voxel_x: expected %h, got %h", e.vx, out_ch.voxel_x); errors++;
        end
        if (out_ch.voxel_y !== e.vy) begin
          $error("voxel_y: expected %h, got %h", e.vy, out_ch.voxel_y); errors++;
        end
        if (out_ch.voxel_z !== e.vz) begin
          $error("voxel_z: expected %h, got %h", e.vz, out_ch.voxel_z); errors++;
        end
        if (out_ch.normal_x !== e.nx) begin
          $error("normal_x: expected %b, got %b", e.nx, out_ch.normal_x); errors++;
        end
        if (out_ch.normal_y !== e.ny) begin
          $error("normal_y: expected %b, got %b", e.ny, out_ch.normal_y); errors++;
        end
        if (out_ch.normal_z !== e.nz) begin
          $error("normal_z: expected %b, got %b", e.nz, out_ch.normal_z); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    // Axis-aligned rays hit on an x, a y and a z face, then a ray runs out of length.
    walk_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16'h4000, 16'h0000, 16'h0000, 3);
    walk_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16'h0000, 16'hC000, 16'h0000, 2);
    walk_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16'h0000, 16'h0000, 16'h4000, 1);
    walk_ray(32'h0001_4000, 32'hFFFF_C000, 32'h0002_0000, 16'h2000, 16'h2000, 16'hE000, -1);
    // A hit on the very first voxel takes its normal from the z step.
    walk_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h1000, 16'h1000, 16'hE000, 0);
    // Extreme origins and directions; a zero direction ends at once.
    walk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h0001, -1);
    walk_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000, -1);
    walk_ray(32'hFFFF_0001, 32'h0000_FFFF, 32'h1234_5678, 16'h0001, 16'hFFFF, 16'h7FFF, -1);
    // Answers with no ray are ignored; a start in mid-ray replaces the ray.
    answer(1'b1);
    answer(1'b0);
    send_req(vrt_pkg::KIND_START, 32'h0000_2000, 32'h0, 32'h0, 16'h3000, 16'h1000, 16'h0,
             1'b0);
    answer(1'b0);
    walk_ray(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 16'h2D41, 16'h2D41, 16'h0, 4);
  endtask

  task automatic test_config_extremes();
    set_max_dist(8'd1);
    walk_ray(32'h0000_8000, 32'h0000_8000, 32'h0, 16'h4000, 16'h1000, 16'h0, -1);
    walk_ray($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 1);
    set_max_dist(8'd255);
    walk_ray(32'h0000_1000, 32'h0000_F000, 32'h0, 16'h4000, 16'hC000, 16'h0800, 40);
    walk_ray($urandom, $urandom, $urandom, 16'h0100, 16'hFF00, 16'h0080, 25);
  endtask

  task automatic test_random_walks(int n_target);
    logic [15:0] d[3];
    int start_items;
    start_items = n_items;
    while (n_items - start_items < n_target) begin
      if (($urandom_range(99) % 25) == 0)
        set_max_dist(($urandom_range(3) == 0) ? 8'($urandom_range(1, 255))
                                                : 8'($urandom_range(1, 12)));
      calm = ((n_items - start_items) > n_target / 2) &&
             ((n_items - start_items) < n_target / 2 + 150);
      if (ray_on && $urandom_range(99) >= 3) begin
        answer($urandom_range(11) == 0);
      end else if (!ray_on && $urandom_range(99) < 5) begin
        answer(1'($urandom_range(1)));
      end else begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(3))
            0: d[i] = 16'h0000;
            1: d[i] = 16'($urandom);
            default: d[i] = 16'($signed(16'($urandom_range(0, 16384))) *
                            ($urandom_range(1) ? 1 : -1));
          endcase
        end
        send_req(vrt_pkg::KIND_START, $urandom, $urandom, $urandom, d[0], d[1], d[2],
                 1'($urandom_range(1)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = vrt_pkg::KIND_START;
    in_ch.origin_x = '0; in_ch.origin_y = '0; in_ch.origin_z = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0;
    in_ch.voxel_solid = 1'b0;
    max_dist = 8'd8;
    for (int i = 0; i < 3; i++) begin
      vox[i] = '0; tmax[i] = '0; tdel[i] = '0; stp[i] = '0;
    end
    last_ax = vrt_pkg::AX_NONE;
    ray_on = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    set_max_dist(8'd8);
    test_random_walks(1150);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests over %0d rays: %0d queries, %0d hits, %0d misses.",
             n_items, n_rays, n_queries, n_hits, n_misses);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
